// ===== design/orbb_pkg.sv =====
// ----------------------------------------------------------------------------
// orbb_pkg: shared types and constants for the opaque region bounding box
// Frame size limits, register indexes, the result record and size clamping.
// ----------------------------------------------------------------------------
package orbb_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int DIM_W     = $clog2(MAX_DIM);
	localparam int SIZE_W    = 13;
	localparam int ALPHA_W   = 8;
	localparam int CFG_IDX_W = 4;

	localparam logic [ALPHA_W-1:0] ALPHA_CLEAR = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 4'd0,
		REG_FRAME_HEIGHT = 4'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [SIZE_W-1:0] left;
		logic [SIZE_W-1:0] top;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} box_t;

	// Status from the tracker toward the handshake logic
	typedef struct packed {
		logic last;
		box_t box;
	} track_stat_t;

	// A size of zero acts as one, anything above the limit acts as the limit
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] reg_val);
		logic [SIZE_W-1:0] res;
		if (reg_val == '0) begin
			res = SIZE_W'(1);
		end else if (reg_val > SIZE_W'(MAX_DIM)) begin
			res = SIZE_W'(MAX_DIM);
		end else begin
			res = reg_val;
		end
		return res;
	endfunction

endpackage

// ===== design/orbb_track.sv =====
// ----------------------------------------------------------------------------
// orbb_track: raster position and opaque extent tracking
// Keeps column/row counters and the least/greatest opaque coordinates, and
// forms the box for the pixel under evaluation. State moves on step.
// ----------------------------------------------------------------------------
module orbb_track (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [orbb_pkg::ALPHA_W-1:0] alpha,
	input  logic [orbb_pkg::SIZE_W-1:0]  width_eff,
	input  logic [orbb_pkg::SIZE_W-1:0]  height_eff,
	output orbb_pkg::track_stat_t        stat
);
	import orbb_pkg::*;

	logic [DIM_W-1:0] col_q, row_q;
	logic [DIM_W-1:0] lcol_q, gcol_q, lrow_q, grow_q;
	logic             seen_q;

	logic [DIM_W-1:0] lcol_n, gcol_n, lrow_n, grow_n;
	logic             seen_n;
	logic             opaque, row_end, frame_end;

	assign opaque    = (alpha != ALPHA_CLEAR);
	assign row_end   = {1'b0, col_q} >= (width_eff - SIZE_W'(1));
	assign frame_end = row_end && ({1'b0, row_q} >= (height_eff - SIZE_W'(1)));

	always_comb begin
		lcol_n = lcol_q;
		gcol_n = gcol_q;
		lrow_n = lrow_q;
		grow_n = grow_q;
		seen_n = seen_q;
		if (opaque) begin
			seen_n = 1'b1;
			if (!seen_q) begin
				lcol_n = col_q;
				gcol_n = col_q;
				lrow_n = row_q;
				grow_n = row_q;
			end else begin
				if (col_q < lcol_q) lcol_n = col_q;
				if (col_q > gcol_q) gcol_n = col_q;
				if (row_q < lrow_q) lrow_n = row_q;
				if (row_q > grow_q) grow_n = row_q;
			end
		end
	end

	always_comb begin
		stat.last = frame_end;
		if (seen_n) begin
			stat.box.left   = {1'b0, lcol_n};
			stat.box.top    = {1'b0, lrow_n};
			stat.box.width  = {1'b0, gcol_n} - {1'b0, lcol_n} + SIZE_W'(1);
			stat.box.height = {1'b0, grow_n} - {1'b0, lrow_n} + SIZE_W'(1);
		end else begin
			stat.box.left   = width_eff;
			stat.box.top    = height_eff;
			stat.box.width  = '0;
			stat.box.height = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			lcol_q <= '0;
			gcol_q <= '0;
			lrow_q <= '0;
			grow_q <= '0;
			seen_q <= 1'b0;
		end else if (step) begin
			if (frame_end) begin
				col_q  <= '0;
				row_q  <= '0;
				lcol_q <= '0;
				gcol_q <= '0;
				lrow_q <= '0;
				grow_q <= '0;
				seen_q <= 1'b0;
			end else begin
				lcol_q <= lcol_n;
				gcol_q <= gcol_n;
				lrow_q <= lrow_n;
				grow_q <= grow_n;
				seen_q <= seen_n;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + DIM_W'(1);
				end else begin
					col_q <= col_q + DIM_W'(1);
				end
			end
		end
	end

endmodule

// ===== design/opaque_region_bounding_box_core.sv =====
// ----------------------------------------------------------------------------
// opaque_region_bounding_box_core: bounding box of opaque pixels per frame
// Input register, tracker logic and a result register with handshakes.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel alpha values stream in raster order on in_valid/in_ready/pixel_alpha,
//   one transfer per pixel. Nonzero alpha marks an opaque pixel. Frame size
//   comes from registers frame_width (index 0) and frame_height (index 1),
//   written over cfg_valid/cfg_ready/cfg_index/cfg_data while the block is
//   idle; cfg_ready is always high and unknown indexes are ignored.
//   One result per frame appears on out_valid/out_ready with box_left,
//   box_top, box_width and box_height; an empty frame gives left = width,
//   top = height and zero extents.
//   Throughput: one pixel per cycle while no frame end waits on a pending
//   result, set by the single tracker pass between the input register and
//   the result register. The frame's last pixel passes through the input
//   register and the tracker, then the result register loads its box.
//   Reset clears the counters, extents and both valid flags; sizes go to 64.
//   When the receiver stalls, pixels keep flowing until the next frame's
//   last pixel reaches the input register, which then holds until the
//   pending result is taken.
// ----------------------------------------------------------------------------
module opaque_region_bounding_box_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [orbb_pkg::ALPHA_W-1:0]   pixel_alpha,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [orbb_pkg::SIZE_W-1:0]    box_left,
	output logic [orbb_pkg::SIZE_W-1:0]    box_top,
	output logic [orbb_pkg::SIZE_W-1:0]    box_width,
	output logic [orbb_pkg::SIZE_W-1:0]    box_height,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [orbb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [orbb_pkg::SIZE_W-1:0]    cfg_data
);
	import orbb_pkg::*;

	logic [SIZE_W-1:0]  frame_width_q, frame_height_q;
	logic               valid_s1;
	logic [ALPHA_W-1:0] alpha_s1;
	logic               out_valid_q;
	box_t               box_q;
	track_stat_t        stat;
	logic               in_xfer, advance, out_load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= SIZE_W'(64);
			frame_height_q <= SIZE_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The held pixel moves on unless it closes a frame and the result slot is busy
	assign advance  = valid_s1 && (!stat.last || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;
	assign out_load = advance && stat.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			alpha_s1 <= pixel_alpha;
		end
	end

	orbb_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.alpha      (alpha_s1),
		.width_eff  (eff_size(frame_width_q)),
		.height_eff (eff_size(frame_height_q)),
		.stat       (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			box_q <= stat.box;
		end
	end

	assign out_valid  = out_valid_q;
	assign box_left   = box_q.left;
	assign box_top    = box_q.top;
	assign box_width  = box_q.width;
	assign box_height = box_q.height;

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> valid_s1)
		else $error("accepted pixel did not reach the input register");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(alpha_s1)))
		else $error("stalled pixel lost or changed");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("frame end did not produce a result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !out_load)
		else $error("pending result overwritten");

	a_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && box_width == '0) |-> (box_height == '0))
		else $error("box with zero width but nonzero height");

endmodule
